FILE: rtl/sscd_pkg.sv
package sscd_pkg;

    // Default build values.
    localparam int NUM_DIGITS_DEF  = 6;
    localparam int SELECT_BITS_DEF = 8;

    // The digit store always holds eight entries; a load fills the first six.
    localparam int STORE_DEPTH = 8;
    localparam int PTR_W       = 3;
    localparam int SEG_BITS    = 8;
    localparam int DIGIT_W     = 4;

    // Shown for a value above the limit and, in both places, for a failed read.
    localparam logic [6:0] MAX_VALUE = 7'd99;

    // Store positions of the three digit pairs, tens digit first.
    localparam logic [PTR_W-1:0] POS_HOURS   = 3'd0;
    localparam logic [PTR_W-1:0] POS_MINUTES = 3'd2;
    localparam logic [PTR_W-1:0] POS_SECONDS = 3'd4;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_REFRESH = 2'd1,
        OP_BLANK   = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    // One input item as held in the input register.
    typedef struct packed {
        t_opcode     opcode;
        logic [7:0]  hours;
        logic [7:0]  minutes;
        logic [7:0]  seconds;
        logic        hours_ok;
        logic        minutes_ok;
        logic        seconds_ok;
    } t_item;

    typedef struct packed {
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] units;
    } t_pair;

    // Saturate a clock value at 99 (or force 99 on a failed read) and split it
    // into two decimal digits. The tens digit is a multiply by 205/2048,
    // which is exact for values up to 99.
    function automatic t_pair split_value(input logic [7:0] value, input logic ok);
        logic [6:0]  v;
        logic [14:0] prod;
        t_pair       pair;
        if (!ok || value > 8'(MAX_VALUE)) begin
            v = MAX_VALUE;
        end else begin
            v = value[6:0];
        end
        prod       = 15'(v) * 15'd205;
        pair.tens  = prod[14:11];
        pair.units = DIGIT_W'(v - 7'(pair.tens) * 7'd10);
        return pair;
    endfunction

    // Segment byte for a digit: bit 0 is segment a, bit 6 is segment g,
    // bit 7 is the decimal point. Codes above 9 show nothing.
    function automatic logic [SEG_BITS-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
        logic [SEG_BITS-1:0] segs;
        case (digit)
            4'd0:    segs = 8'h3F;
            4'd1:    segs = 8'h06;
            4'd2:    segs = 8'h5B;
            4'd3:    segs = 8'h4F;
            4'd4:    segs = 8'h66;
            4'd5:    segs = 8'h6D;
            4'd6:    segs = 8'h7C;
            4'd7:    segs = 8'h07;
            4'd8:    segs = 8'h7F;
            4'd9:    segs = 8'h67;
            default: segs = 8'h00;
        endcase
        return segs;
    endfunction

endpackage

FILE: rtl/sscd_frame.sv
module sscd_frame
    import sscd_pkg::*;
#(
    parameter int NUM_DIGITS  = NUM_DIGITS_DEF,
    parameter int SELECT_BITS = SELECT_BITS_DEF,
    localparam int FRAME_BITS = SEG_BITS + SELECT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_item                 i_item,
    input  logic                  i_take,
    output logic [FRAME_BITS-1:0] o_frame
);

    logic [DIGIT_W-1:0] r_digit [STORE_DEPTH];
    logic               r_blank [STORE_DEPTH];
    logic [PTR_W-1:0]   r_ptr;

    t_pair              w_hours;
    t_pair              w_minutes;
    t_pair              w_seconds;
    logic [PTR_W:0]     w_ptr_inc;
    logic [PTR_W-1:0]   n_ptr;
    logic [SEG_BITS-1:0]    w_segs;
    logic [SELECT_BITS-1:0] w_sel;

    // Digit pairs for a load.
    always_comb begin
        w_hours   = split_value(i_item.hours, i_item.hours_ok);
        w_minutes = split_value(i_item.minutes, i_item.minutes_ok);
        w_seconds = split_value(i_item.seconds, i_item.seconds_ok);
    end

    // The pointer wraps after the last digit.
    always_comb begin
        w_ptr_inc = {1'b0, r_ptr} + (PTR_W+1)'(1);
        if (w_ptr_inc >= (PTR_W+1)'(NUM_DIGITS)) begin
            n_ptr = '0;
        end else begin
            n_ptr = w_ptr_inc[PTR_W-1:0];
        end
    end

    // Segments and one-hot select for the frame of the current item.
    // A blank digit sends empty segments with no select bit set.
    always_comb begin
        w_segs = '0;
        w_sel  = '0;
        if (i_item.opcode == OP_BLANK) begin
            for (int i = 0; i < SELECT_BITS; i++) begin
                w_sel[i] = (i == NUM_DIGITS - 1);
            end
        end else if (!r_blank[r_ptr]) begin
            w_segs = seg_of(r_digit[r_ptr]);
            for (int i = 0; i < SELECT_BITS; i++) begin
                w_sel[i] = (i == int'(r_ptr));
            end
        end
        o_frame = {w_segs, w_sel};
    end

    // Digit store and pointer update as items leave the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_digit[i] <= '0;
                r_blank[i] <= 1'b0;
            end
            r_ptr <= '0;
        end else if (i_take) begin
            case (i_item.opcode)
                OP_LOAD: begin
                    r_digit[POS_HOURS]       <= w_hours.tens;
                    r_digit[POS_HOURS+1]     <= w_hours.units;
                    r_digit[POS_MINUTES]     <= w_minutes.tens;
                    r_digit[POS_MINUTES+1]   <= w_minutes.units;
                    r_digit[POS_SECONDS]     <= w_seconds.tens;
                    r_digit[POS_SECONDS+1]   <= w_seconds.units;
                    // Leading hour zero is hidden unless the hour is zero.
                    r_blank[POS_HOURS]       <= i_item.hours_ok &&
                                                (w_hours.tens == '0) &&
                                                (w_hours.units != '0);
                    r_blank[POS_HOURS+1]     <= 1'b0;
                    r_blank[POS_MINUTES]     <= 1'b0;
                    r_blank[POS_MINUTES+1]   <= 1'b0;
                    r_blank[POS_SECONDS]     <= 1'b0;
                    r_blank[POS_SECONDS+1]   <= 1'b0;
                    r_ptr                    <= '0;
                end
                OP_REFRESH: begin
                    r_ptr <= n_ptr;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: rtl/sscd_shift.sv
module sscd_shift
    import sscd_pkg::*;
#(
    parameter int FRAME_BITS = SEG_BITS + SELECT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [FRAME_BITS-1:0] i_frame,
    input  logic                  i_ready,
    output logic                  o_valid,
    output logic                  o_bit,
    output logic                  o_last,
    output logic                  o_free
);

    localparam int CNT_W = $clog2(FRAME_BITS + 1);

    logic [FRAME_BITS-1:0] r_frame;
    logic [CNT_W-1:0]      r_cnt;
    logic                  w_xfer;

    assign o_valid = (r_cnt != '0);
    assign o_last  = (r_cnt == CNT_W'(1));
    assign o_bit   = r_frame[FRAME_BITS-1];
    assign w_xfer  = o_valid && i_ready;
    // A new frame may load while the last bit of the current one transfers.
    assign o_free  = !o_valid || (w_xfer && o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= CNT_W'(FRAME_BITS);
        end else if (w_xfer) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Frame bits go out MSB first.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_frame <= i_frame;
        end else if (w_xfer) begin
            r_frame <= {r_frame[FRAME_BITS-2:0], 1'b0};
        end
    end

endmodule

FILE: rtl/seven_segment_clock_display_driver_top.sv
// Clock display driver for a chain of serial shift registers feeding a
// multiplexed seven-segment display. A load item (tuser opcode 0) stores the
// hours, minutes and seconds as six decimal digits and produces no output; a
// refresh item (opcode 1) sends the next digit and a blank item (opcode 2)
// sends empty segments for the last digit. Each frame is 8 + SELECT_BITS
// serial bits (16 by default), one bit per output transfer, MSB first: the
// segment byte (dp, g, f, e, d, c, b, a) and then the one-hot digit select,
// with tlast on the final bit where the latch pulse belongs. The bit
// serializer sets the rate: a frame item occupies it until its last bit has
// transferred, and the next frame item is taken in the cycle its last bit
// transfers, so frames stream without gaps. Loads and unused opcodes do not
// wait for the serializer. There is no clearing pass after reset.
module seven_segment_clock_display_driver_top
    import sscd_pkg::*;
#(
    parameter int NUM_DIGITS  = NUM_DIGITS_DEF,
    parameter int SELECT_BITS = SELECT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] hours, [15:8] minutes, [23:16] seconds, [24] hours_ok,
    // [25] minutes_ok, [26] seconds_ok, [31:27] zero
    input  logic [31:0] s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] serial_bit, [7:1] zero
    output logic [7:0]  m_axis_tdata,
    // latch_after
    output logic        m_axis_tlast
);

    localparam int FRAME_BITS = SEG_BITS + SELECT_BITS;

    logic                  r_in_valid;
    t_item                 r_item;
    logic                  w_is_frame;
    logic                  w_take;
    logic                  w_shift_load;
    logic                  w_shift_free;
    logic                  w_bit;
    logic [FRAME_BITS-1:0] w_frame;

    // Input register; an item leaves it when the serializer can take its frame.
    assign w_is_frame    = (r_item.opcode == OP_REFRESH) || (r_item.opcode == OP_BLANK);
    assign w_take        = r_in_valid && (!w_is_frame || w_shift_free);
    assign w_shift_load  = w_take && w_is_frame;
    assign s_axis_tready = !r_in_valid || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.opcode     <= t_opcode'(s_axis_tuser);
            r_item.hours      <= s_axis_tdata[7:0];
            r_item.minutes    <= s_axis_tdata[15:8];
            r_item.seconds    <= s_axis_tdata[23:16];
            r_item.hours_ok   <= s_axis_tdata[24];
            r_item.minutes_ok <= s_axis_tdata[25];
            r_item.seconds_ok <= s_axis_tdata[26];
        end
    end

    // Digit store and frame assembly.
    sscd_frame #(
        .NUM_DIGITS  (NUM_DIGITS),
        .SELECT_BITS (SELECT_BITS)
    ) u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (r_item),
        .i_take  (w_take),
        .o_frame (w_frame)
    );

    // Bit serializer driving the output stream.
    sscd_shift #(
        .FRAME_BITS (FRAME_BITS)
    ) u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_shift_load),
        .i_frame (w_frame),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_bit   (w_bit),
        .o_last  (m_axis_tlast),
        .o_free  (w_shift_free)
    );

    assign m_axis_tdata = {7'b0, w_bit};

    // A frame only loads into an idle serializer or one finishing its last bit.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shift_load |-> (!m_axis_tvalid || (m_axis_tready && m_axis_tlast)))
        else $error("frame loaded over a frame in progress");

    // A frame starts only from a refresh or blank item.
    a_frame_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_shift_load))
        else $error("output started without a frame item");

    // The input register only stalls behind a frame that is still shifting.
    a_stall_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_take) |-> (m_axis_tvalid && w_is_frame))
        else $error("input stalled with the serializer free");

endmodule

FILE: tb/seven_segment_clock_display_driver_top_tb.sv
`timescale 1ns / 1ps

module seven_segment_clock_display_driver_top_tb;
    import sscd_pkg::*;

    // Segment bytes for decimal digits, bit 0 is segment a and bit 7 is dp.
    localparam logic [7:0] DIGIT_SEGMENTS [0:9] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7C, 8'h07, 8'h7F, 8'h67
    };
    localparam logic [7:0] BLANK_SEGMENTS = 8'h00;
    localparam int         FAIL_DIGIT     = 9;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         PHASE_ITEMS    = 117;
    localparam int         MAX_PRINTED    = 40;

    // One serial bit as the display shift chain should see it.
    typedef struct packed {
        logic serial_bit;
        logic latch_after;
    } t_frame_bit;

    // Scoreboard: keeps its own digit store and predicts every serial bit.
    class display_scoreboard;
        logic [DIGIT_W-1:0] digit_code [STORE_DEPTH];
        logic               digit_off [STORE_DEPTH];
        int                 scan_pos;
        t_frame_bit         bit_queue [$];
        int                 error_count;
        int                 bits_checked;
        int                 loads_seen;
        int                 refreshes_seen;
        int                 blanks_seen;
        int                 unused_seen;

        function new();
            for (int i = 0; i < STORE_DEPTH; i++) begin
                digit_code[i] = '0;
                digit_off[i]  = 1'b0;
            end
            scan_pos       = 0;
            error_count    = 0;
            bits_checked   = 0;
            loads_seen     = 0;
            refreshes_seen = 0;
            blanks_seen    = 0;
            unused_seen    = 0;
        endfunction

        // Split a clock value into tens and units, 99 on overflow or failed read.
        function void store_pair(int pos, logic [7:0] value, logic ok);
            int v;
            v = ok ? ((value > 8'd99) ? 99 : int'(value)) : FAIL_DIGIT * 11;
            digit_code[pos]     = DIGIT_W'(v / 10);
            digit_code[pos + 1] = DIGIT_W'(v % 10);
            digit_off[pos]      = 1'b0;
            digit_off[pos + 1]  = 1'b0;
        endfunction

        // Queue one frame: segment byte MSB first, then the one-hot select.
        function void queue_frame(logic [7:0] segs, int sel);
            t_frame_bit fb;
            for (int i = 7; i >= 0; i--) begin
                fb.serial_bit  = segs[i];
                fb.latch_after = 1'b0;
                bit_queue.push_back(fb);
            end
            for (int i = SELECT_BITS_DEF - 1; i >= 0; i--) begin
                fb.serial_bit  = (i == sel);
                fb.latch_after = (i == 0);
                bit_queue.push_back(fb);
            end
        endfunction

        // Called for every accepted input transfer.
        function void note_input(t_opcode op, logic [7:0] hours, logic [7:0] minutes,
                                 logic [7:0] seconds, logic hours_ok, logic minutes_ok,
                                 logic seconds_ok);
            logic [7:0] segs;
            case (op)
                OP_LOAD: begin
                    loads_seen++;
                    store_pair(int'(POS_SECONDS), seconds, seconds_ok);
                    store_pair(int'(POS_MINUTES), minutes, minutes_ok);
                    store_pair(int'(POS_HOURS), hours, hours_ok);
                    // Leading hour zero goes dark unless the hour is exactly zero.
                    if (hours_ok && digit_code[0] == 0 && digit_code[1] != 0) begin
                        digit_off[0] = 1'b1;
                    end
                    scan_pos = 0;
                end
                OP_REFRESH: begin
                    refreshes_seen++;
                    if (digit_off[scan_pos]) begin
                        queue_frame(BLANK_SEGMENTS, -1);
                    end else begin
                        segs = (digit_code[scan_pos] <= 9) ?
                               DIGIT_SEGMENTS[digit_code[scan_pos]] : BLANK_SEGMENTS;
                        queue_frame(segs, scan_pos);
                    end
                    scan_pos = (scan_pos + 1 >= NUM_DIGITS_DEF) ? 0 : scan_pos + 1;
                end
                OP_BLANK: begin
                    blanks_seen++;
                    queue_frame(BLANK_SEGMENTS, NUM_DIGITS_DEF - 1);
                end
                default: begin
                    unused_seen++;
                end
            endcase
        endfunction

        task report(string msg);
            error_count++;
            if (error_count <= MAX_PRINTED) begin
                $display("MISMATCH: %s", msg);
            end
        endtask

        // Called for every accepted output transfer.
        task check_result(logic serial_bit, logic latch_after);
            t_frame_bit want;
            if (bit_queue.size() == 0) begin
                report($sformatf("unexpected output transfer (bit %0b, last %0b)",
                                 serial_bit, latch_after));
                return;
            end
            want = bit_queue.pop_front();
            bits_checked++;
            if (serial_bit !== want.serial_bit) begin
                report($sformatf("serial bit #%0d: got %b, expected %b",
                                 bits_checked, serial_bit, want.serial_bit));
            end
            if (latch_after !== want.latch_after) begin
                report($sformatf("latch flag on bit #%0d: got %b, expected %b",
                                 bits_checked, latch_after, want.latch_after));
            end
        endtask

        function int pending();
            return bit_queue.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [7:0] hours, [15:8] minutes, [23:16] seconds, [24] hours_ok,
    // [25] minutes_ok, [26] seconds_ok, [31:27] zero
    logic [31:0] s_axis_tdata;
    // [1:0] opcode
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] serial_bit, [7:1] zero
    logic [7:0]  m_axis_tdata;
    // latch_after
    logic        m_axis_tlast;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        hold_req = 1'b0;
    int          hold_left = 0;
    display_scoreboard sb;

    seven_segment_clock_display_driver_top #(
        .NUM_DIGITS  (NUM_DIGITS_DEF),
        .SELECT_BITS (SELECT_BITS_DEF)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: random back-pressure, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: every value sampled here is the one from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata[0], m_axis_tlast);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_input(t_opcode'(s_axis_tuser), s_axis_tdata[7:0],
                              s_axis_tdata[15:8], s_axis_tdata[23:16], s_axis_tdata[24],
                              s_axis_tdata[25], s_axis_tdata[26]);
            end
        end
    end

    // Offer one item, with random idle cycles first, and wait for its transfer.
    task send_item(t_opcode op, logic [7:0] hours, logic [7:0] minutes,
                   logic [7:0] seconds, logic hours_ok, logic minutes_ok,
                   logic seconds_ok);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'd0, seconds_ok, minutes_ok, hours_ok, seconds, minutes, hours};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    // Mostly plausible clock values, with overflow values and edges mixed in.
    function automatic logic [7:0] pick_value();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5) begin
            return 8'($urandom_range(99));
        end else if (sel < 8) begin
            return 8'($urandom_range(255));
        end
        case ($urandom_range(6))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd9;
            3:       return 8'd10;
            4:       return 8'd99;
            5:       return 8'd100;
            default: return 8'd255;
        endcase
    endfunction

    // Random items: loads followed by runs of refreshes, some blanks and noise.
    task random_items(int count);
        int      done;
        int      r;
        t_opcode op;
        done = 0;
        while (done < count) begin
            r  = $urandom_range(99);
            op = (r < 15) ? OP_LOAD : (r < 77) ? OP_REFRESH : (r < 91) ? OP_BLANK : OP_NONE;
            send_item(op, pick_value(), pick_value(), pick_value(),
                      $urandom_range(99) < 85, $urandom_range(99) < 85,
                      $urandom_range(99) < 85);
            if (op != OP_NONE) begin
                done++;
            end
        end
    endtask

    task refresh_run(int count);
        for (int i = 0; i < count; i++) begin
            send_item(OP_REFRESH, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        end
    endtask

    // Main sequence.
    initial begin
        sb = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_LOAD;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: midnight shows a real zero hour, every digit once.
        tx_idle_pct <= 23;
        rx_idle_pct <= 50;
        send_item(OP_LOAD, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b1);
        refresh_run(6);
        // Single-digit hour blanks its tens digit; seven refreshes wrap the scan.
        send_item(OP_LOAD, 8'd5, 8'd59, 8'd9, 1'b1, 1'b1, 1'b1);
        refresh_run(7);
        // Saturation at 99, a load mid-scan restarts it, blank frame and unused code.
        send_item(OP_LOAD, 8'd255, 8'd100, 8'd99, 1'b1, 1'b1, 1'b1);
        send_item(OP_BLANK, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        refresh_run(2);
        send_item(OP_NONE, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
        // Failed reads show 99, and a failed hour never blanks.
        send_item(OP_LOAD, 8'd1, 8'd0, 8'd1, 1'b0, 1'b0, 1'b0);
        refresh_run(2);
        send_item(OP_BLANK, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);

        // Random phases with shifting idle patterns.
        random_items(PHASE_ITEMS);
        tx_idle_pct <= 50;
        rx_idle_pct <= 23;
        random_items(PHASE_ITEMS);
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        // Stall the receiver long enough for the input side to back up.
        s_axis_tvalid <= 1'b0;
        hold_req      <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        random_items(PHASE_ITEMS);
        s_axis_tvalid <= 1'b0;

        // Drain, then give the block time to show any stray output.
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (50) @(posedge i_clk);

        $display("Run covered %0d loads, %0d refresh frames, %0d blank frames, %0d unused codes,",
                 sb.loads_seen, sb.refreshes_seen, sb.blanks_seen, sb.unused_seen);
        $display("with %0d serial bits checked and %0d mismatches.",
                 sb.bits_checked, sb.error_count);
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("Timeout: simulation did not finish in time.");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
